@@ rtl/core/bmrt_pkg.sv @@
package bmrt_pkg;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned VAL_W = 32;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_REMOVE = 2'd1,
		FN_LESS   = 2'd2,
		FN_PARITY = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic publish;
	} bmrt_cmd_t;

	// two-level count: groups of four, then sum of groups
	function automatic logic [CNT_W-1:0] count_flags(input logic [DEPTH-1:0] f);
		logic [CNT_W-1:0] total;
		logic [2:0]       part;
		total = '0;
		for (int g = 0; g < DEPTH; g += 4) begin
			part = '0;
			for (int k = 0; k < 4; k++) begin
				if (g + k < DEPTH) begin
					part = part + {2'b00, f[g+k]};
				end
			end
			total = total + CNT_W'(part);
		end
		return total;
	endfunction

endpackage

@@ rtl/core/bmrt_in_if.sv @@
interface bmrt_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                func;
	logic signed [bmrt_pkg::VAL_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

@@ rtl/core/bmrt_out_if.sv @@
interface bmrt_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [bmrt_pkg::CNT_W-1:0]  tally;
	logic [bmrt_pkg::CNT_W-1:0]  occupancy;

	modport source (output valid, output status, output tally, output occupancy, input ready);
	modport sink (input valid, input status, input tally, input occupancy, output ready);
endinterface

@@ rtl/core/bmrt_ctrl.sv @@
module bmrt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	output bmrt_pkg::bmrt_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_SUM  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE) || ((state_q == S_SUM) && out_free);
	assign cmd.load    = in_valid && in_ready;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.publish = (state_q == S_SUM) && out_free;
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_SUM;
			end
			S_SUM: begin
				if (cmd.publish) state_d = cmd.load ? S_EXEC : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/bmrt_datapath.sv @@
module bmrt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bmrt_pkg::bmrt_cmd_t               cmd,
	input  logic [1:0]                        func,
	input  logic signed [bmrt_pkg::VAL_W-1:0] value,
	output logic [1:0]                        status,
	output logic [bmrt_pkg::CNT_W-1:0]        tally,
	output logic [bmrt_pkg::CNT_W-1:0]        occupancy
);

	localparam int unsigned D  = bmrt_pkg::DEPTH;
	localparam int unsigned CW = bmrt_pkg::CNT_W;

	logic [1:0]                        func_q;
	logic signed [bmrt_pkg::VAL_W-1:0] key_q;
	logic signed [bmrt_pkg::VAL_W-1:0] entries_q [D];
	logic [$clog2(D+1)-1:0]            fill_q;

	logic [D-1:0] flags_s1;
	logic [1:0]   status_s1;

	logic [1:0]    status_q;
	logic [CW-1:0] tally_q;
	logic [CW-1:0] occupancy_q;

	logic [D-1:0] occ, nz, eq, lt, par, match, first, tail;
	logic         full, empty, do_add, do_rm;

	assign status    = status_q;
	assign tally     = tally_q;
	assign occupancy = occupancy_q;

	always_comb begin
		for (int i = 0; i < D; i++) begin
			occ[i] = ($clog2(D+1))'(i) < fill_q;
			nz[i]  = entries_q[i] != '0;
			eq[i]  = entries_q[i] == key_q;
			lt[i]  = entries_q[i] < key_q;
			par[i] = entries_q[i][0] == key_q[0];
		end
		match  = occ & eq;
		// lowest matching slot, then every slot from it upward
		first  = match & (~match + D'(1));
		tail   = ~(first - D'(1));
		full   = fill_q >= ($clog2(D+1))'(D);
		empty  = fill_q == '0;
		do_add = (func_q == bmrt_pkg::FN_ADD) && !full;
		do_rm  = (func_q == bmrt_pkg::FN_REMOVE) && !empty && (match != '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			key_q  <= value;
		end
		if (cmd.exec) begin
			unique case (func_q)
				bmrt_pkg::FN_ADD: begin
					status_s1 <= full ? bmrt_pkg::ST_FULL : bmrt_pkg::ST_OK;
					flags_s1  <= '0;
				end
				bmrt_pkg::FN_REMOVE: begin
					status_s1 <= empty ? bmrt_pkg::ST_EMPTY :
					             (match == '0) ? bmrt_pkg::ST_NOTFOUND : bmrt_pkg::ST_OK;
					flags_s1  <= '0;
				end
				bmrt_pkg::FN_LESS: begin
					status_s1 <= bmrt_pkg::ST_OK;
					flags_s1  <= occ & nz & lt;
				end
				default: begin
					status_s1 <= bmrt_pkg::ST_OK;
					flags_s1  <= occ & nz & par;
				end
			endcase
		end
		if (cmd.publish) begin
			status_q    <= status_s1;
			tally_q     <= bmrt_pkg::count_flags(flags_s1);
			occupancy_q <= CW'(fill_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < D; i++) begin
				entries_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			if (do_add) begin
				fill_q <= fill_q + 1'b1;
				for (int i = 0; i < D; i++) begin
					if (fill_q == ($clog2(D+1))'(i)) entries_q[i] <= key_q;
				end
			end else if (do_rm) begin
				fill_q <= fill_q - 1'b1;
				// slots above the fill are zero, so the last one pulls in zero
				for (int i = 0; i < D; i++) begin
					if (tail[i]) entries_q[i] <= (i + 1 < D) ? entries_q[(i+1) % D] : '0;
				end
			end
		end
	end

endmodule

@@ rtl/core/bounded_multiset_rank_table_top.sv @@
// Bounded multiset with rank count.
// Input channel in_ch carries func and value; output channel out_ch carries
// status, tally and occupancy. Both use valid/ready; a transfer happens on a
// rising edge with valid and ready high. Every input transfer yields exactly
// one output transfer, in order.
// Each taken item passes through S_EXEC and then S_SUM; a new item is taken
// in S_IDLE or while S_SUM hands on its result, never in S_EXEC. S_EXEC
// compares the key against all 16 slots and applies the add, the shift-down
// remove or the flagging; S_SUM counts the flagged slots into the output register.
// The output register parts the two sides: while a result waits, the next
// item is still taken and worked on; it stalls in S_SUM only until the
// waiting result is transferred, and in_ch.ready drops meanwhile.
// Reset (arst_n low) empties the set, clears all slots and drops out_ch.valid;
// the block takes items in the first cycle after reset is released.
module bounded_multiset_rank_table_top (
	input logic         clk,
	input logic         arst_n,
	bmrt_in_if.sink     in_ch,
	bmrt_out_if.source  out_ch
);

	bmrt_pkg::bmrt_cmd_t cmd;

	bmrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	bmrt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.func      (in_ch.func),
		.value     (in_ch.value),
		.status    (out_ch.status),
		.tally     (out_ch.tally),
		.occupancy (out_ch.occupancy)
	);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.occupancy <= bmrt_pkg::CNT_W'(bmrt_pkg::DEPTH))
		else $error("occupancy above capacity");

	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.tally <= out_ch.occupancy)
		else $error("tally above occupancy");

	a_err_no_tally: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status != bmrt_pkg::ST_OK) |-> out_ch.tally == '0)
		else $error("error status with nonzero tally");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == bmrt_pkg::ST_FULL)
		|-> out_ch.occupancy == bmrt_pkg::CNT_W'(bmrt_pkg::DEPTH))
		else $error("full status below capacity");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status == bmrt_pkg::ST_EMPTY) |-> out_ch.occupancy == '0)
		else $error("empty status with entries present");

endmodule
